### rtl/sparse_sign_projection_hash_macros.svh
// Assertion helpers used by the top-level RTL file.
`ifndef SPARSE_SIGN_PROJECTION_HASH_MACROS_SVH
`define SPARSE_SIGN_PROJECTION_HASH_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define SSPH_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ssph: same-cycle check failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define SSPH_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ssph: next-cycle check failed");

`endif

### rtl/ssph_pkg.sv
`default_nettype none

package ssph_pkg;

  // Fixed widths of the item channel fields, the rows and the sums.
  localparam int unsigned DimW     = 6;
  localparam int unsigned MaskBits = 16;
  localparam int unsigned SampleW  = 16;
  localparam int unsigned AccW     = 32;
  localparam int unsigned RowW     = 2 * MaskBits;

  typedef enum logic {
    OpLoad   = 1'b0,
    OpSample = 1'b1
  } op_e;

  // Control of the accumulate stage, handed from the top to the bank.
  typedef struct packed {
    logic advance;
    logic last;
    logic in_range;
  } acc_ctrl_t;

endpackage

`default_nettype wire

### rtl/ssph_row_mem.sv
`default_nettype none

module ssph_row_mem import ssph_pkg::*; #(
  parameter int unsigned Depth = 64,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [RowW-1:0]  wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [RowW-1:0]  rdata_o
);

  logic [RowW-1:0] mem [Depth];

  // Store a row on a load transfer.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read; hold the data while no new sample is read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

### rtl/ssph_accum.sv
`default_nettype none

module ssph_accum import ssph_pkg::*; #(
  parameter int unsigned NumHashes = 16,
  localparam int unsigned Active = (NumHashes < MaskBits) ? NumHashes : MaskBits
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire acc_ctrl_t                 ctrl_i,
  input  wire logic [RowW-1:0]           row_i,
  input  wire logic signed [SampleW-1:0] sample_i,
  output logic [MaskBits-1:0]            hash_bits_o
);

  logic [AccW-1:0] acc_q [Active];
  logic [AccW-1:0] sum   [Active];
  logic [AccW-1:0] value;

  // Sign-extend the sample into the accumulator width.
  assign value = {{(AccW - SampleW){sample_i[SampleW-1]}}, sample_i};

  for (genvar h = 0; h < MaskBits; h++) begin : g_hash
    if (h < Active) begin : g_on
      logic add_en;
      logic sub_en;

      // Both or neither mask bit set: no contribution.
      assign add_en = ctrl_i.in_range & row_i[h] & ~row_i[MaskBits + h];
      assign sub_en = ctrl_i.in_range & row_i[MaskBits + h] & ~row_i[h];

      always_comb begin
        sum[h] = acc_q[h];
        if (add_en) begin
          sum[h] = acc_q[h] + value;
        end else if (sub_en) begin
          sum[h] = acc_q[h] - value;
        end
      end

      // Advance the sum; clear it after the last sample of a vector.
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          acc_q[h] <= '0;
        end else if (ctrl_i.advance) begin
          acc_q[h] <= ctrl_i.last ? '0 : sum[h];
        end
      end

      assign hash_bits_o[h] = sum[h][AccW-1];
    end else begin : g_off
      assign hash_bits_o[h] = 1'b0;
    end
  end

endmodule

`default_nettype wire

### rtl/sparse_sign_projection_hash.sv
// Sparse signed projection hash.
// Input channel (in_valid_i / in_stall_o) takes one item per cycle. A load
// item (operation 0) stores the plus and minus masks of one dimension; a
// sample item (operation 1) adds or subtracts its value in every hash sum
// as that dimension's row says. A sample with last set emits one result on
// the output channel (out_valid_o / out_stall_i) and clears all sums.
// Path: the row read is registered beside the sample, the add into the
// sums is combinational, and a last sample's sign bits load the result register.
// Throughput: one item per cycle while in_stall_o is low; the row memory
// has one write and one read port, and a load followed directly by a
// sample of that row is served. Stall: the result register holds while
// out_stall_i is high; non-last items keep flowing, and only a last sample
// that meets a full, stalled result register raises in_stall_o until the
// result is taken. Reset: clears all sums and valid flags; rows hold no
// reset value and each must be loaded before a sample uses it.
`default_nettype none

module sparse_sign_projection_hash import ssph_pkg::*; #(
  parameter int unsigned DIMENSIONS = 64,
  parameter int unsigned NUM_HASHES = 16
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_stall_o,
  input  wire logic                      operation_i,
  input  wire logic [DimW-1:0]           dim_index_i,
  input  wire logic [MaskBits-1:0]       plus_mask_i,
  input  wire logic [MaskBits-1:0]       minus_mask_i,
  input  wire logic signed [SampleW-1:0] sample_i,
  input  wire logic                      last_i,
  output logic                           out_valid_o,
  input  wire logic                      out_stall_i,
  output logic [MaskBits-1:0]            hash_bits_o
);

`include "sparse_sign_projection_hash_macros.svh"

  localparam int unsigned AddrW = $clog2(DIMENSIONS);

  logic                      in_xfer;
  logic                      is_sample;
  logic                      in_range;
  logic [AddrW-1:0]          addr;
  logic [RowW-1:0]           row;
  logic                      s1_valid_q, s1_valid_d;
  logic                      s1_last_q;
  logic                      s1_range_q;
  logic signed [SampleW-1:0] s1_sample_q;
  logic                      s1_adv;
  acc_ctrl_t                 ctrl;
  logic [MaskBits-1:0]       hash_bits;
  logic                      out_valid_q, out_valid_d;
  logic [MaskBits-1:0]       out_hash_q;

  // Decode the input transfer.
  assign in_xfer   = in_valid_i & ~in_stall_o;
  assign is_sample = (op_e'(operation_i) == OpSample);
  assign in_range  = ({{(32 - DimW){1'b0}}, dim_index_i} < 32'(DIMENSIONS));
  assign addr      = AddrW'(dim_index_i);

  ssph_row_mem #(
    .Depth(DIMENSIONS)
  ) u_row_mem (
    .clk_i  (clk_i),
    .we_i   (in_xfer & ~is_sample & in_range),
    .waddr_i(addr),
    .wdata_i({minus_mask_i, plus_mask_i}),
    .re_i   (in_xfer & is_sample),
    .raddr_i(addr),
    .rdata_o(row)
  );

  // Accumulate stage advances unless its last sample finds the result held.
  assign s1_adv     = s1_valid_q & ~(s1_last_q & out_valid_q & out_stall_i);
  assign in_stall_o = s1_valid_q & ~s1_adv;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_xfer & is_sample) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  // Capture the sample beside its row read.
  always_ff @(posedge clk_i) begin
    if (in_xfer & is_sample) begin
      s1_last_q   <= last_i;
      s1_range_q  <= in_range;
      s1_sample_q <= sample_i;
    end
  end

  assign ctrl.advance  = s1_adv;
  assign ctrl.last     = s1_last_q;
  assign ctrl.in_range = s1_range_q;

  ssph_accum #(
    .NumHashes(NUM_HASHES)
  ) u_accum (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (ctrl),
    .row_i      (row),
    .sample_i   (s1_sample_q),
    .hash_bits_o(hash_bits)
  );

  // Result register: load on a last sample, drop once the transfer is taken.
  always_comb begin
    out_valid_d = out_valid_q;
    if (s1_adv & s1_last_q) begin
      out_valid_d = 1'b1;
    end else if (~out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv & s1_last_q) begin
      out_hash_q <= hash_bits;
    end
  end

  assign out_valid_o = out_valid_q;
  assign hash_bits_o = out_hash_q;

  `SSPH_ASSERT_NOW(a_stall_cause, in_stall_o, s1_valid_q && s1_last_q && out_valid_q)
  `SSPH_ASSERT_NEXT(a_last_emits, s1_adv && s1_last_q, out_valid_q)
  `SSPH_ASSERT_NEXT(a_load_no_stage, in_xfer && !is_sample && !in_stall_o, !s1_valid_q)

endmodule

`default_nettype wire

### bench/tb_sparse_sign_projection_hash.sv
module tb_sparse_sign_projection_hash;
  timeunit 1ns;
  timeprecision 1ps;

  import ssph_pkg::*;

  localparam int unsigned NumDims     = 64;
  localparam int unsigned NumHashes   = 16;
  localparam int unsigned ClkHalf     = 2;
  localparam int unsigned CycleLimit  = 20_000;
  localparam int unsigned SettleCyc   = 8;
  localparam int unsigned RandomItems = 1800;
  localparam int unsigned DirRows     = 22;
  localparam int unsigned MaxPrinted  = 20;

  // One input transfer; typed/want carry a hand-computed hash word
  typedef struct packed {
    op_e                        op;
    logic [DimW-1:0]            dim;
    logic [MaskBits-1:0]        plus;
    logic [MaskBits-1:0]        minus;
    logic signed [SampleW-1:0]  sample;
    logic                       last;
    logic                       typed;
    logic [MaskBits-1:0]        want;
  } hash_item_t;

  logic                       clk_i = 1'b0;
  logic                       rst_ni;
  logic                       in_valid_i;
  logic                       in_stall_o;
  logic                       operation_i;
  logic [DimW-1:0]            dim_index_i;
  logic [MaskBits-1:0]        plus_mask_i;
  logic [MaskBits-1:0]        minus_mask_i;
  logic signed [SampleW-1:0]  sample_i;
  logic                       last_i;
  logic                       out_valid_o;
  logic                       out_stall_i;
  logic [MaskBits-1:0]        hash_bits_o;

  // Shadow of the projection table and the running hash sums
  logic [MaskBits-1:0] row_plus  [NumDims];
  logic [MaskBits-1:0] row_minus [NumDims];
  logic [AccW-1:0]     hash_sum  [NumHashes];
  logic [MaskBits-1:0] pending_hashes [$];

  int unsigned cycle_count = 0;
  int unsigned err_count   = 0;
  int unsigned load_count  = 0;
  int unsigned sample_count = 0;
  int unsigned words_seen  = 0;
  logic        calm;

  // Directed rows: extremes, both/neither mask bits, last on a load,
  // load directly followed by a sample of that row, reloading a row
  hash_item_t dir_rows [DirRows] = '{
    '{OpLoad,   6'd0,  16'hFFFF, 16'h0000, 16'sd0,     1'b0, 1'b0, 16'h0000},
    '{OpSample, 6'd0,  16'h0000, 16'h0000, -16'sd1,    1'b1, 1'b1, 16'hFFFF},
    '{OpSample, 6'd0,  16'h0000, 16'h0000, 16'sd32767, 1'b1, 1'b1, 16'h0000},
    '{OpLoad,   6'd1,  16'h0000, 16'hFFFF, 16'sd0,     1'b1, 1'b0, 16'h0000},
    '{OpSample, 6'd1,  16'h0000, 16'h0000, 16'sd1,     1'b1, 1'b1, 16'hFFFF},
    '{OpSample, 6'd1,  16'hFFFF, 16'hFFFF, 16'sh8000,  1'b1, 1'b1, 16'h0000},
    '{OpLoad,   6'd2,  16'hFFFF, 16'hFFFF, 16'sh8000,  1'b0, 1'b0, 16'h0000},
    '{OpSample, 6'd2,  16'h0000, 16'h0000, 16'sh8000,  1'b1, 1'b1, 16'h0000},
    '{OpLoad,   6'd3,  16'h0000, 16'h0000, 16'sd0,     1'b0, 1'b0, 16'h0000},
    '{OpSample, 6'd3,  16'h0000, 16'h0000, -16'sd5,    1'b1, 1'b1, 16'h0000},
    '{OpLoad,   6'd63, 16'hAAAA, 16'h5555, 16'sd0,     1'b0, 1'b0, 16'h0000},
    '{OpSample, 6'd63, 16'h0000, 16'h0000, 16'sh8000,  1'b1, 1'b1, 16'hAAAA},
    '{OpLoad,   6'd4,  16'h00FF, 16'h0F0F, 16'sd0,     1'b0, 1'b0, 16'h0000},
    '{OpSample, 6'd4,  16'h0000, 16'h0000, -16'sd100,  1'b0, 1'b0, 16'h0000},
    '{OpSample, 6'd0,  16'h0000, 16'h0000, 16'sd50,    1'b0, 1'b0, 16'h0000},
    '{OpSample, 6'd4,  16'h0000, 16'h0000, -16'sd100,  1'b1, 1'b0, 16'h0000},
    '{OpSample, 6'd63, 16'h0000, 16'h0000, 16'sd32767, 1'b0, 1'b0, 16'h0000},
    '{OpLoad,   6'd5,  16'h1234, 16'h4321, 16'sd0,     1'b0, 1'b0, 16'h0000},
    '{OpSample, 6'd5,  16'h0000, 16'h0000, -16'sd7,    1'b1, 1'b0, 16'h0000},
    '{OpLoad,   6'd0,  16'h0000, 16'hFFFF, 16'sd0,     1'b1, 1'b0, 16'h0000},
    '{OpSample, 6'd0,  16'h0000, 16'h0000, 16'sd0,     1'b1, 1'b1, 16'h0000},
    '{OpSample, 6'd63, 16'hFFFF, 16'hFFFF, -16'sd1,    1'b1, 1'b1, 16'hAAAA}
  };

  sparse_sign_projection_hash #(
    .DIMENSIONS(NumDims),
    .NUM_HASHES(NumHashes)
  ) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .operation_i (operation_i),
    .dim_index_i (dim_index_i),
    .plus_mask_i (plus_mask_i),
    .minus_mask_i(minus_mask_i),
    .sample_i    (sample_i),
    .last_i      (last_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .hash_bits_o (hash_bits_o)
  );

  always #(ClkHalf) clk_i = ~clk_i;

  task automatic report_mismatch(input string what);
    if (err_count < MaxPrinted) begin
      $display("tb: MISMATCH at cycle %0d: %s", cycle_count, what);
    end
    err_count++;
  endtask

  // Apply one item to the shadow state; return 1 with the hash word on a last sample
  function automatic logic fold_into_sums(input hash_item_t it,
                                          output logic [MaskBits-1:0] bits);
    logic [AccW-1:0] value;
    logic            add;
    logic            sub;
    bits = '0;
    if (it.op == OpLoad) begin
      row_plus[it.dim]  = it.plus;
      row_minus[it.dim] = it.minus;
      return 1'b0;
    end
    value = {{(AccW-SampleW){it.sample[SampleW-1]}}, it.sample};
    for (int h = 0; h < NumHashes && h < MaskBits; h++) begin
      add = row_plus[it.dim][h];
      sub = row_minus[it.dim][h];
      if (add && !sub) begin
        hash_sum[h] += value;
      end else if (sub && !add) begin
        hash_sum[h] -= value;
      end
    end
    if (!it.last) begin
      return 1'b0;
    end
    for (int h = 0; h < NumHashes && h < MaskBits; h++) begin
      bits[h]     = hash_sum[h][AccW-1];
      hash_sum[h] = '0;
    end
    return 1'b1;
  endfunction

  function automatic logic [MaskBits-1:0] random_mask();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return MaskBits'($urandom);
    endcase
  endfunction

  function automatic hash_item_t random_item(input bit burst);
    hash_item_t it;
    it.op    = ($urandom_range(0, 99) < 12) ? OpLoad : OpSample;
    it.dim   = DimW'($urandom_range(0, NumDims - 1));
    it.plus  = random_mask();
    it.minus = random_mask();
    case ($urandom_range(0, 9))
      0:       it.sample = 16'sh8000;
      1:       it.sample = 16'sd32767;
      2:       it.sample = '0;
      3:       it.sample = '1;
      default: it.sample = SampleW'($urandom);
    endcase
    // Short vectors in a burst window so lasts pile up against a stalled output
    it.last  = burst ? 1'($urandom_range(0, 1)) : 1'($urandom_range(0, 7) == 0);
    it.typed = 1'b0;
    it.want  = '0;
    return it;
  endfunction

  // Drive one item, hold it until the transfer, then predict
  task automatic send_item(input hash_item_t it);
    logic [MaskBits-1:0] bits;
    logic                has_word;
    while (!calm && $urandom_range(0, 99) < 7) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    operation_i  <= it.op;
    dim_index_i  <= it.dim;
    plus_mask_i  <= it.plus;
    minus_mask_i <= it.minus;
    sample_i     <= it.sample;
    last_i       <= it.last;
    @(posedge clk_i);
    while (in_stall_o !== 1'b0) @(posedge clk_i);
    has_word = fold_into_sums(it, bits);
    if (it.op == OpLoad) begin
      load_count++;
    end else begin
      sample_count++;
    end
    if (has_word) begin
      pending_hashes.push_back(it.typed ? it.want : bits);
    end
  endtask

  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_hashes.size() != 0) @(posedge clk_i);
  endtask

  // Random output stall, off during the calm window
  always @(posedge clk_i) begin
    out_stall_i <= !calm && ($urandom_range(0, 99) < 7);
  end

  // Check each hash word transfer against the oldest expectation
  always @(posedge clk_i) begin : check_words
    logic [MaskBits-1:0] want_bits;
    if (rst_ni === 1'b1 && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (pending_hashes.size() == 0) begin
        report_mismatch($sformatf("unexpected hash word %h", hash_bits_o));
      end else begin
        want_bits = pending_hashes.pop_front();
        words_seen++;
        if (hash_bits_o !== want_bits) begin
          report_mismatch($sformatf("hash_bits %h, want %h", hash_bits_o, want_bits));
        end
      end
    end
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("tb_sparse_sign_projection_hash: done, errors");
      $finish;
    end
  end

  initial begin
    hash_item_t it;
    rst_ni       <= 1'b0;
    in_valid_i   <= 1'b0;
    operation_i  <= OpLoad;
    dim_index_i  <= '0;
    plus_mask_i  <= '0;
    minus_mask_i <= '0;
    sample_i     <= '0;
    last_i       <= 1'b0;
    out_stall_i  <= 1'b0;
    calm         <= 1'b0;
    for (int h = 0; h < NumHashes; h++) hash_sum[h] = '0;
    for (int d = 0; d < NumDims; d++) begin
      row_plus[d]  = '0;
      row_minus[d] = '0;
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed rows
    for (int i = 0; i < DirRows; i++) send_item(dir_rows[i]);

    // Load every row before random samples touch it
    for (int d = 0; d < NumDims; d++) begin
      it       = random_item(1'b0);
      it.op    = OpLoad;
      it.dim   = DimW'(d);
      send_item(it);
    end

    // Random vectors with interleaved row reloads
    for (int i = 0; i < RandomItems; i++) begin
      calm <= (i >= 300 && i < 700);
      if (i == 900 || i == 1500) begin
        wait_for_results();
      end
      send_item(random_item(i >= 1000 && i < 1200));
    end
    calm <= 1'b0;

    wait_for_results();
    repeat (SettleCyc) @(posedge clk_i);
    if (pending_hashes.size() != 0) begin
      report_mismatch($sformatf("%0d hash words never arrived", pending_hashes.size()));
    end

    $display("tb: %0d row loads and %0d samples sent, %0d hash words compared",
             load_count, sample_count, words_seen);
    $display("tb: covered mask extremes, cancelling masks, row reloads, output backpressure");
    if (err_count == 0) begin
      $display("tb_sparse_sign_projection_hash: done, clean");
    end else begin
      $display("tb_sparse_sign_projection_hash: done, errors");
    end
    $finish;
  end

endmodule

### files.f
+incdir+rtl
rtl/ssph_pkg.sv
rtl/ssph_row_mem.sv
rtl/ssph_accum.sv
rtl/sparse_sign_projection_hash.sv
bench/tb_sparse_sign_projection_hash.sv
